@@ design/exs_pkg.sv @@
// exs_pkg: shared types and constants for the exchange sorter.
// Holds payload structs, control struct and FSM state type.
// No dependencies.
`default_nettype none

package exs_pkg;

  localparam int VALUE_W           = 16;
  localparam int MAX_ITEMS_DEFAULT = 64;

  // Smallest signed value; cell 0 sees it as its left neighbor.
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_res;
    logic                      last_res;
    logic                      swapped;
    logic                      overflow;
  } out_item_t;

  typedef struct packed {
    logic insert;  // place the incoming value into the chain
    logic shift;   // move every entry one cell toward cell 0
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

`default_nettype wire

@@ design/exs_cell.sv @@
// exs_cell: one slot of the sorting chain.
// Depends on exs_pkg (VALUE_W, cell_ctrl_t).
`default_nettype none

module exs_cell (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire exs_pkg::cell_ctrl_t                ctrl,
  input  wire logic signed [exs_pkg::VALUE_W-1:0] din,
  input  wire logic                               left_valid,
  input  wire logic signed [exs_pkg::VALUE_W-1:0] left_value,
  input  wire logic                               right_valid,
  input  wire logic signed [exs_pkg::VALUE_W-1:0] right_value,
  output logic                                    valid,
  output logic signed [exs_pkg::VALUE_W-1:0]      value
);

  logic                               valid_next;
  logic signed [exs_pkg::VALUE_W-1:0] value_next;
  logic                               below_left;
  logic                               below_own;

  assign below_left = $signed(din) < $signed(left_value);
  assign below_own  = $signed(din) < $signed(value);

  always_comb begin
    valid_next = valid;
    value_next = value;
    if (ctrl.shift) begin
      valid_next = right_valid;
      value_next = right_value;
    end else if (ctrl.insert) begin
      // new value lands here or pushes the left entry in; entries not above it stay
      if (!valid || below_own) begin
        if (left_valid) begin
          valid_next = 1'b1;
          value_next = below_left ? left_value : din;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    value <= value_next;
  end

endmodule

`default_nettype wire

@@ design/exs_ctrl.sv @@
// exs_ctrl: load/drain sequencer, fill count and run flags.
// Depends on exs_pkg (types, state_t, VALUE_W).
`default_nettype none

module exs_ctrl #(
  parameter int MAX_ITEMS = exs_pkg::MAX_ITEMS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  input  wire exs_pkg::in_item_t   item,
  output logic                     item_ready,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output exs_pkg::cell_ctrl_t      ctrl,
  output logic                     last_res,
  output logic                     swapped,
  output logic                     overflow
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  exs_pkg::state_t                    state, state_next;
  logic [CNT_W-1:0]                   count, count_next;
  logic                               swap_flag, swap_flag_next;
  logic                               drop_flag, drop_flag_next;
  logic signed [exs_pkg::VALUE_W-1:0] prev_value, prev_value_next;

  logic in_xfer;
  logic out_xfer;
  logic room;
  logic final_out;

  assign in_xfer   = item_valid && item_ready;
  assign out_xfer  = res_valid && res_ready;
  assign room      = count != CNT_W'(MAX_ITEMS);
  assign final_out = count == CNT_W'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      exs_pkg::ST_LOAD: begin
        if (in_xfer && item.last) state_next = exs_pkg::ST_DRAIN;
      end
      exs_pkg::ST_DRAIN: begin
        if (out_xfer && final_out) state_next = exs_pkg::ST_LOAD;
      end
      default: state_next = exs_pkg::ST_LOAD;
    endcase
  end

  // outputs; ready/valid are constant within a state, so the strobes use
  // the other side of each handshake directly
  always_comb begin
    item_ready  = 1'b0;
    res_valid   = 1'b0;
    ctrl.insert = 1'b0;
    ctrl.shift  = 1'b0;
    case (state)
      exs_pkg::ST_LOAD: begin
        item_ready  = 1'b1;
        ctrl.insert = item_valid && room;
      end
      exs_pkg::ST_DRAIN: begin
        res_valid  = 1'b1;
        ctrl.shift = res_ready;
      end
      default: ;
    endcase
  end

  assign last_res = final_out;
  assign swapped  = swap_flag;
  assign overflow = drop_flag;

  // count and run flags
  always_comb begin
    count_next      = count;
    swap_flag_next  = swap_flag;
    drop_flag_next  = drop_flag;
    prev_value_next = prev_value;
    if (ctrl.insert) begin
      count_next      = count + CNT_W'(1);
      prev_value_next = item.value;
      if (count != '0 && $signed(item.value) < $signed(prev_value)) begin
        swap_flag_next = 1'b1;  // input had a descent
      end
    end else if (in_xfer) begin
      drop_flag_next = 1'b1;
    end
    if (ctrl.shift) begin
      count_next = count - CNT_W'(1);
      if (final_out) begin
        swap_flag_next = 1'b0;
        drop_flag_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= exs_pkg::ST_LOAD;
      count     <= '0;
      swap_flag <= 1'b0;
      drop_flag <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      swap_flag <= swap_flag_next;
      drop_flag <= drop_flag_next;
    end
    prev_value <= prev_value_next;
  end

endmodule

`default_nettype wire

@@ design/exchange_sorter_top.sv @@
// exchange_sorter_top: collects a set of signed values and returns it in ascending order.
// Depends on exs_pkg, exs_cell, exs_ctrl.
//
//   channel | dir | payload              | handshake
//   --------+-----+----------------------+------------------------
//   item    | in  | exs_pkg::in_item_t   | item_valid / item_ready
//   res     | out | exs_pkg::out_item_t  | res_valid / res_ready
//
// Load: one item per cycle; each value is inserted into its sorted slot of the
//   cell chain in the cycle it is accepted (broadcast compare in every cell); items
//   past capacity are dropped and set the overflow flag.
// Drain: after the item marked last, one result per cycle while res_ready is high,
//   taken from cell 0 while the chain shifts toward it.
// No item is taken while a set drains; res_ready low simply holds the chain.
// Reset (rst, synchronous) empties the chain and the counters; no clearing pass.
`default_nettype none

module exchange_sorter_top #(
  parameter int MAX_ITEMS = exs_pkg::MAX_ITEMS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire exs_pkg::in_item_t   item,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output exs_pkg::out_item_t       res
);

  exs_pkg::cell_ctrl_t ctrl;
  logic                last_res;
  logic                swapped;
  logic                overflow;

  // chain contents; cell 0 holds the smallest value
  logic                               cell_valid [MAX_ITEMS];
  logic signed [exs_pkg::VALUE_W-1:0] cell_value [MAX_ITEMS];

  exs_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .ctrl       (ctrl),
    .last_res   (last_res),
    .swapped    (swapped),
    .overflow   (overflow)
  );

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
      logic                               lv, rv;
      logic signed [exs_pkg::VALUE_W-1:0] lval, rval;

      // cell 0 sees an occupied neighbor holding the minimum, so it always
      // takes the incoming value when it has to move
      if (gi == 0) begin : g_head
        assign lv   = 1'b1;
        assign lval = exs_pkg::VALUE_MIN;
      end else begin : g_body
        assign lv   = cell_valid[gi-1];
        assign lval = cell_value[gi-1];
      end

      // tail cell shifts in an empty slot
      if (gi == MAX_ITEMS - 1) begin : g_tail
        assign rv   = 1'b0;
        assign rval = '0;
      end else begin : g_mid
        assign rv   = cell_valid[gi+1];
        assign rval = cell_value[gi+1];
      end

      exs_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .din         (item.value),
        .left_valid  (lv),
        .left_value  (lval),
        .right_valid (rv),
        .right_value (rval),
        .valid       (cell_valid[gi]),
        .value       (cell_value[gi])
      );
    end
  endgenerate

  // cell 0 is the output register during drain
  assign res.value_res = cell_value[0];
  assign res.last_res  = last_res;
  assign res.swapped   = swapped;
  assign res.overflow  = overflow;

endmodule

`default_nettype wire

@@ design/exs_checker.sv @@
// exs_checker: port-level checks for exchange_sorter_top, bound to the top.
// Depends on exs_pkg (payload types).
`default_nettype none

module exs_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               item_valid,
  input wire logic               item_ready,
  input wire exs_pkg::in_item_t  item,
  input wire logic               res_valid,
  input wire logic               res_ready,
  input wire exs_pkg::out_item_t res
);

  logic res_xfer;
  assign res_xfer = res_valid && res_ready;

  // load and drain never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && res_valid))
    else $error("item_ready and res_valid high together");

  // results of one set come out in ascending order
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    res_xfer && !res.last_res |=>
      res_valid && ($signed(res.value_res) >= $signed($past(res.value_res))))
    else $error("result order not ascending");

  // run flags are the same on every result of a set
  a_flags_steady: assert property (@(posedge clk) disable iff (rst)
    res_xfer && !res.last_res |=>
      res.swapped == $past(res.swapped) && res.overflow == $past(res.overflow))
    else $error("run flags changed within a set");

  // after the final result the block is ready for a new set
  a_reload: assert property (@(posedge clk) disable iff (rst)
    res_xfer && res.last_res |=> item_ready && !res_valid)
    else $error("not back in load after final result");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

endmodule

bind exchange_sorter_top exs_checker u_exs_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_valid),
  .item_ready (item_ready),
  .item       (item),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .res        (res)
);

`default_nettype wire

@@ test/sort_checker.sv @@
// sort_checker: watches both channels of exchange_sorter_top, predicts the sorted
// output of every closed set and compares it, field by field, with each result transfer.
// Depends on exs_pkg.
module sort_checker #(
  parameter int CAPACITY = exs_pkg::MAX_ITEMS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  exs_pkg::in_item_t  item,
  input  logic               res_valid,
  input  logic               res_ready,
  input  exs_pkg::out_item_t res,
  output int                 err_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import exs_pkg::*;

  logic signed [VALUE_W-1:0] sort_store [CAPACITY];
  int unsigned               set_count;
  bit                        set_dropped;
  out_item_t                 sorted_q [$];

  initial begin
    err_count = 0;
    pending   = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    err_count++;
  endtask

  // Store one value (or note the drop); a last item closes the set, so sort
  // it and queue one expected result per stored value.
  task automatic absorb_value(input in_item_t it);
    logic signed [VALUE_W-1:0] tmp;
    bit                        exchanged;
    out_item_t                 r;
    if (set_count < CAPACITY) begin
      sort_store[set_count] = it.value;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!it.last) return;
    exchanged = 1'b0;
    for (int i = 0; i < set_count; i++) begin
      for (int j = 0; j < i; j++) begin
        if (sort_store[j] > sort_store[i]) begin
          tmp           = sort_store[j];
          sort_store[j] = sort_store[i];
          sort_store[i] = tmp;
          exchanged     = 1'b1;
        end
      end
    end
    for (int k = 0; k < set_count; k++) begin
      r.value_res = sort_store[k];
      r.last_res  = (k == set_count - 1);
      r.swapped   = exchanged;
      r.overflow  = set_dropped;
      sorted_q.push_back(r);
    end
    set_count   = 0;
    set_dropped = 1'b0;
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (sorted_q.size() == 0) begin
      report_mismatch($sformatf("result %0d with nothing expected", got.value_res));
      return;
    end
    want = sorted_q.pop_front();
    if (got.value_res !== want.value_res)
      report_mismatch($sformatf("value_res %0d, expected %0d", got.value_res, want.value_res));
    if (got.last_res !== want.last_res)
      report_mismatch($sformatf("last_res %b, expected %b", got.last_res, want.last_res));
    if (got.swapped !== want.swapped)
      report_mismatch($sformatf("swapped %b, expected %b", got.swapped, want.swapped));
    if (got.overflow !== want.overflow)
      report_mismatch($sformatf("overflow %b, expected %b", got.overflow, want.overflow));
  endtask

  // Results of a set always come after the transfer that closed it, so
  // handle the output side first.
  always @(posedge clk) begin
    if (rst) begin
      set_count   = 0;
      set_dropped = 1'b0;
      sorted_q.delete();
    end else begin
      if (res_valid && res_ready) compare_result(res);
      if (item_valid && item_ready) absorb_value(item);
    end
    pending = sorted_q.size();
  end

endmodule

@@ test/testbench.sv @@
// testbench: drives sets of signed values into exchange_sorter_top and drains the sorted
// results under random idling and a long receiver stall; sort_checker does the compare.
// Depends on exs_pkg, exchange_sorter_top, sort_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import exs_pkg::*;

  localparam int HOLD_CYCLES = 300;   // long receiver stall
  localparam int DRAIN_SLACK = 100;   // cycles after the last expected result

  // Value patterns for a random set.
  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_NARROW,    // few distinct values, many duplicates
    SHAPE_RISING,    // already in order, no exchange expected
    SHAPE_FALLING,   // reverse order
    SHAPE_EXTREME    // range limits, zero, minus one or random
  } shape_t;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  in_item_t  item;
  logic      res_valid;
  logic      res_ready;
  out_item_t res;

  int err_count;
  int pending;

  // Idle odds in percent, set per phase.
  int snd_idle     = 0;
  int rcv_idle     = 0;
  bit hold_request = 1'b0;
  int items_sent   = 0;

  exchange_sorter_top uut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  sort_checker sort_check (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .err_count  (err_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random ready, plus one long hold once a drain has started when
  // asked for. The sender keeps offering meanwhile, so the input backs up.
  initial begin
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && res_valid) begin
        hold_request = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // One transfer on the item channel. Valid stays up from one item to the
  // next unless an idle cycle is drawn.
  task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic l);
    while ($urandom_range(0, 99) < snd_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{value: v, last: l};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_set(input shortint vals[$]);
    foreach (vals[k]) send_item(vals[k], k == vals.size() - 1);
  endtask

  task automatic random_set(input int len);
    shortint vals[$];
    shape_t  shape;
    shape = shape_t'($urandom_range(SHAPE_RANDOM, SHAPE_EXTREME));
    for (int k = 0; k < len; k++) begin
      case (shape)
        SHAPE_NARROW: begin
          vals.push_back(shortint'(int'($urandom_range(0, 6)) - 3));
        end
        SHAPE_EXTREME: begin
          case ($urandom_range(0, 4))
            0: vals.push_back(shortint'(VALUE_MIN));
            1: vals.push_back(16'sh7fff);
            2: vals.push_back(16'sh0000);
            3: vals.push_back(-16'sh0001);
            default: vals.push_back(shortint'($urandom));
          endcase
        end
        default: begin
          vals.push_back(shortint'($urandom));
        end
      endcase
    end
    if (shape == SHAPE_RISING) vals.sort();
    if (shape == SHAPE_FALLING) vals.rsort();
    send_set(vals);
  endtask

  // Mostly short sets; now and then one near or past capacity so that the
  // store fills and later items, the last one included, get dropped.
  task automatic run_phase(input int s_idle, input int r_idle, input int quota);
    snd_idle = s_idle;
    rcv_idle = r_idle;
    // open each phase with a full set and a long stall on the first drain seen
    hold_request = 1'b1;
    random_set(MAX_ITEMS_DEFAULT);
    while (items_sent < quota) begin
      if ($urandom_range(0, 99) < 8) random_set($urandom_range(62, 70));
      else random_set($urandom_range(1, 12));
    end
  endtask

  initial begin
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: single-value sets at both limits, reverse and in-order sets
    // across the range, duplicates only, alternating signs.
    snd_idle = 0;
    rcv_idle = 0;
    send_set('{16'sh7fff});
    send_set('{shortint'(VALUE_MIN)});
    send_set('{16'sh7fff, 16'sh0000, -16'sh0001, shortint'(VALUE_MIN)});
    send_set('{shortint'(VALUE_MIN), -16'sh0001, 16'sh0000, 16'sh0001, 16'sh7fff});
    send_set('{16'sh0005, 16'sh0005, 16'sh0005});
    send_set('{16'sh0003, -16'sh0003, 16'sh0003, -16'sh0003});

    run_phase(24, 58, 130);
    run_phase(58, 24, 245);
    run_phase(0, 0, 360);
    item_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
design/exs_pkg.sv
design/exs_cell.sv
design/exs_ctrl.sv
design/exchange_sorter_top.sv
design/exs_checker.sv
test/sort_checker.sv
test/testbench.sv
